FILE: design/wppe_pkg.sv
`timescale 1ns / 1ps

package wppe_pkg;

  localparam int LED_COUNT = 64;
  localparam int LED_AW    = 6;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_START = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_SCALE_EN   = 3'd1,
    REG_ONE_PULSE  = 3'd2,
    REG_ZERO_PULSE = 3'd3,
    REG_TAIL_SLOTS = 3'd4
  } reg_idx_t;

  localparam logic [6:0] BRIGHT_MAX      = 7'd100;
  localparam logic [6:0] BRIGHT_RST      = 7'd100;
  localparam logic       SCALE_EN_RST    = 1'b1;
  localparam logic [7:0] ONE_PULSE_RST   = 8'd40;
  localparam logic [7:0] ZERO_PULSE_RST  = 8'd20;
  localparam logic [7:0] TAIL_SLOTS_RST  = 8'd50;
  localparam logic [4:0] BIT_POS_FIRST   = 5'd23;

  // x / 100 for x up to 25500 is exactly (x * 5243) >> 19
  localparam int          DIV100_SHIFT   = 19;
  localparam logic [12:0] DIV100_RECIP   = 13'd5243;
  localparam int          BSCALE_W       = 20;
  localparam int          PROD_W         = 8 + BSCALE_W;

endpackage

FILE: design/ws2812_pixel_pulse_encoder.sv
`timescale 1ns / 1ps
// channel   ports                                          handshake
// -------   ---------------------------------------------  ---------------------------
// input     in_req_type in_led_index in_red in_green in_blue  start high, busy low
// result    out_duty out_active out_frame_done             out_valid, one cycle
// config    psel penable pwrite paddr pwdata prdata pready APB, pready tied high
//
// one item is accepted in every cycle while busy is low; a slot tick passes the
// item register, colour store read, scale and select, then the output register
// the colour store is a 64 x 24 memory with one read port at the LED position;
// per-entry valid flops clear it at once on reset or a clear request
// reset is synchronous; busy is high during reset and in the cycle after it
// results cannot be stalled: out_valid is a one-cycle strobe
module ws2812_pixel_pulse_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_led_index,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  output logic [7:0]  out_duty,
  output logic        out_active,
  output logic        out_frame_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wppe_pkg::*;

  // configuration
  logic [6:0]          brightness_r;
  logic [BSCALE_W-1:0] bscale_r;
  logic                scale_en_r;
  logic [7:0]          one_pulse_r;
  logic [7:0]          zero_pulse_r;
  logic [7:0]          tail_slots_r;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;
  logic [6:0]          bright_sat;

  // item register
  logic                busy_r;
  logic                item_v_r;
  logic [1:0]          item_req_r;
  logic [5:0]          item_idx_r;
  logic [23:0]         item_grb_r;
  req_t                item_req;

  // frame state
  logic                sending_r, sending_nxt;
  logic                in_tail_r, in_tail_nxt;
  logic [LED_AW-1:0]   led_pos_r, led_pos_nxt;
  logic [4:0]          bit_pos_r, bit_pos_nxt;
  logic [7:0]          tail_cnt_r, tail_cnt_nxt;
  logic [7:0]          tail_inc;

  // colour store
  logic [23:0]         color_mem [LED_COUNT];
  logic [LED_COUNT-1:0] ent_valid_r;
  logic                mem_wr;
  logic                mem_clr;

  // slot stage
  logic                s2_v_r, s2_v_nxt;
  logic                s2_act_r, s2_act_nxt;
  logic                s2_done_r, s2_done_nxt;
  logic                s2_data_r, s2_data_nxt;
  logic [4:0]          s2_bit_r;
  logic [23:0]         rd_word_r;
  logic                rd_valid_r;

  logic [23:0]         word;
  logic [7:0]          chan_raw;
  logic [PROD_W-1:0]   chan_prod;
  logic [7:0]          chan_sent;
  logic [7:0]          duty;

  logic                out_valid_r;
  logic [7:0]          out_duty_r;
  logic                out_active_r;
  logic                out_done_r;

  assign pready = 1'b1;
  assign busy   = busy_r;

  assign cfg_wr     = psel && penable && pwrite;
  assign cfg_idx    = reg_idx_t'(paddr[4:2]);
  assign bright_sat = (pwdata[6:0] > BRIGHT_MAX) ? BRIGHT_MAX : pwdata[6:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= BRIGHT_RST;
      bscale_r     <= BSCALE_W'(BRIGHT_RST) * BSCALE_W'(DIV100_RECIP);
      scale_en_r   <= SCALE_EN_RST;
      one_pulse_r  <= ONE_PULSE_RST;
      zero_pulse_r <= ZERO_PULSE_RST;
      tail_slots_r <= TAIL_SLOTS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BRIGHTNESS: begin
          brightness_r <= bright_sat;
          bscale_r     <= BSCALE_W'(bright_sat) * BSCALE_W'(DIV100_RECIP);
        end
        REG_SCALE_EN:   scale_en_r   <= pwdata[0];
        REG_ONE_PULSE:  one_pulse_r  <= pwdata[7:0];
        REG_ZERO_PULSE: zero_pulse_r <= pwdata[7:0];
        REG_TAIL_SLOTS: tail_slots_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_BRIGHTNESS: prdata = {25'd0, brightness_r};
      REG_SCALE_EN:   prdata = {31'd0, scale_en_r};
      REG_ONE_PULSE:  prdata = {24'd0, one_pulse_r};
      REG_ZERO_PULSE: prdata = {24'd0, zero_pulse_r};
      REG_TAIL_SLOTS: prdata = {24'd0, tail_slots_r};
      default:        prdata = '0;
    endcase
  end

  // item register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      item_v_r <= 1'b0;
    end else begin
      busy_r   <= 1'b0;
      item_v_r <= start && !busy_r;
    end
    if (start && !busy_r) begin
      item_req_r <= in_req_type;
      item_idx_r <= in_led_index;
      item_grb_r <= {in_green, in_red, in_blue};
    end
  end

  assign item_req = req_t'(item_req_r);
  assign mem_wr   = item_v_r && (item_req == REQ_WRITE) &&
                    ({1'b0, item_idx_r} < 7'(LED_COUNT));
  assign mem_clr  = item_v_r && (item_req == REQ_CLEAR);
  assign tail_inc = tail_cnt_r + 8'd1;

  always_comb begin
    sending_nxt  = sending_r;
    in_tail_nxt  = in_tail_r;
    led_pos_nxt  = led_pos_r;
    bit_pos_nxt  = bit_pos_r;
    tail_cnt_nxt = tail_cnt_r;
    s2_v_nxt     = 1'b0;
    s2_act_nxt   = 1'b0;
    s2_done_nxt  = 1'b0;
    s2_data_nxt  = 1'b0;
    if (item_v_r) begin
      unique case (item_req)
        REQ_WRITE, REQ_CLEAR: ;
        REQ_START: begin
          if (!sending_r) begin
            sending_nxt  = 1'b1;
            in_tail_nxt  = 1'b0;
            led_pos_nxt  = '0;
            bit_pos_nxt  = BIT_POS_FIRST;
            tail_cnt_nxt = '0;
          end
        end
        REQ_TICK: begin
          s2_v_nxt = 1'b1;
          if (sending_r) begin
            s2_act_nxt = 1'b1;
            if (in_tail_r) begin
              tail_cnt_nxt = tail_inc;
              // wrap of the count also ends the frame
              if (tail_inc == 8'd0 || tail_inc >= tail_slots_r) begin
                s2_done_nxt = 1'b1;
              end
            end else begin
              s2_data_nxt = 1'b1;
              if (bit_pos_r == 5'd0) begin
                bit_pos_nxt = BIT_POS_FIRST;
                if (led_pos_r == LED_AW'(LED_COUNT - 1)) begin
                  if (tail_slots_r == 8'd0) begin
                    s2_done_nxt = 1'b1;
                  end else begin
                    in_tail_nxt  = 1'b1;
                    tail_cnt_nxt = '0;
                  end
                end else begin
                  led_pos_nxt = led_pos_r + LED_AW'(1);
                end
              end else begin
                bit_pos_nxt = bit_pos_r - 5'd1;
              end
            end
            if (s2_done_nxt) begin
              sending_nxt  = 1'b0;
              in_tail_nxt  = 1'b0;
              led_pos_nxt  = '0;
              bit_pos_nxt  = BIT_POS_FIRST;
              tail_cnt_nxt = '0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r  <= 1'b0;
      in_tail_r  <= 1'b0;
      led_pos_r  <= '0;
      bit_pos_r  <= BIT_POS_FIRST;
      tail_cnt_r <= '0;
      s2_v_r     <= 1'b0;
      s2_act_r   <= 1'b0;
      s2_done_r  <= 1'b0;
      s2_data_r  <= 1'b0;
    end else begin
      sending_r  <= sending_nxt;
      in_tail_r  <= in_tail_nxt;
      led_pos_r  <= led_pos_nxt;
      bit_pos_r  <= bit_pos_nxt;
      tail_cnt_r <= tail_cnt_nxt;
      s2_v_r     <= s2_v_nxt;
      s2_act_r   <= s2_act_nxt;
      s2_done_r  <= s2_done_nxt;
      s2_data_r  <= s2_data_nxt;
    end
    s2_bit_r <= bit_pos_r;
  end

  // colour store and its valid flags
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      color_mem[item_idx_r[LED_AW-1:0]] <= item_grb_r;
    end
    rd_word_r <= color_mem[led_pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || mem_clr) begin
      ent_valid_r <= '0;
    end else if (mem_wr) begin
      ent_valid_r[item_idx_r[LED_AW-1:0]] <= 1'b1;
    end
    rd_valid_r <= ent_valid_r[led_pos_r];
  end

  // scale the one channel that holds the current bit
  assign word = rd_valid_r ? rd_word_r : 24'd0;

  always_comb begin
    case (s2_bit_r[4:3])
      2'd2:    chan_raw = word[23:16];
      2'd1:    chan_raw = word[15:8];
      default: chan_raw = word[7:0];
    endcase
  end

  assign chan_prod = PROD_W'(chan_raw) * PROD_W'(bscale_r);
  assign chan_sent = scale_en_r ? chan_prod[DIV100_SHIFT +: 8] : chan_raw;
  assign duty      = !s2_data_r ? 8'd0 :
                     chan_sent[s2_bit_r[2:0]] ? one_pulse_r : zero_pulse_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s2_v_r;
    end
    out_duty_r   <= duty;
    out_active_r <= s2_act_r;
    out_done_r   <= s2_done_r;
  end

  assign out_valid      = out_valid_r;
  assign out_duty       = out_duty_r;
  assign out_active     = out_active_r;
  assign out_frame_done = out_done_r;

endmodule

FILE: design/wppe_checker.sv
`timescale 1ns / 1ps
module wppe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_req_type,
  input logic        out_valid,
  input logic [7:0]  out_duty,
  input logic        out_active,
  input logic        out_frame_done,
  input logic        pready
);
  import wppe_pkg::*;

  // every result comes from an accepted slot tick, through the item register, slot stage and output register
  a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && (in_req_type == REQ_TICK), 3))
    else $error("result beat without a matching slot tick");

  a_done_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> out_active)
    else $error("frame_done outside a frame");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_active) |-> (out_duty == 8'd0))
    else $error("idle slot with non-zero duty");

  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind ws2812_pixel_pulse_encoder wppe_checker u_wppe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_req_type    (in_req_type),
  .out_valid      (out_valid),
  .out_duty       (out_duty),
  .out_active     (out_active),
  .out_frame_done (out_frame_done),
  .pready         (pready)
);

FILE: dv/tb_ws2812_pixel_pulse_encoder.sv
`timescale 1ns / 1ps

module tb_ws2812_pixel_pulse_encoder;
  import wppe_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic [7:0] duty;
    logic       active;
    logic       frame_done;
  } slot_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        start          = 1'b0;
  logic        busy;
  logic [1:0]  in_req_type    = REQ_TICK;
  logic [5:0]  in_led_index   = '0;
  logic [7:0]  in_red         = '0;
  logic [7:0]  in_green       = '0;
  logic [7:0]  in_blue        = '0;
  logic        out_valid;
  logic [7:0]  out_duty;
  logic        out_active;
  logic        out_frame_done;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [4:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  // pulse encoder mirror: colour store, frame position and register copies
  logic [23:0] grb_store [LED_COUNT];
  logic        frame_on;
  int unsigned cur_led;
  logic [4:0]  cur_bit;
  logic        tail_phase;
  logic [7:0]  tail_sent;
  logic [6:0]  bright_r;
  logic        scale_r;
  logic [7:0]  one_r;
  logic [7:0]  zero_r;
  logic [7:0]  tail_r;
  slot_t       pending_slots [$];

  int mismatches   = 0;
  int stall_cycles = 0;
  bit gaps_on      = 1'b1;

  ws2812_pixel_pulse_encoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_led_index   (in_led_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_duty       (out_duty),
    .out_active     (out_active),
    .out_frame_done (out_frame_done),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] scaled_channel(input logic [7:0] ch);
    int unsigned prod;
    if (!scale_r) return ch;
    prod = int'(ch) * int'(bright_r);
    return 8'(prod / 100);
  endfunction

  function automatic void end_frame();
    frame_on   = 1'b0;
    tail_phase = 1'b0;
    cur_led    = 0;
    cur_bit    = BIT_POS_FIRST;
    tail_sent  = '0;
  endfunction

  function automatic void predict_slot(input req_t rq, input logic [5:0] idx,
                                       input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
    slot_t       s;
    logic [23:0] word;
    s = '0;
    case (rq)
      REQ_WRITE: begin
        if (idx < LED_COUNT) grb_store[idx] = {g, r, b};
      end
      REQ_CLEAR: begin
        foreach (grb_store[i]) grb_store[i] = '0;
      end
      REQ_START: begin
        if (!frame_on) begin
          end_frame();
          frame_on = 1'b1;
        end
      end
      default: begin
        if (frame_on) begin
          s.active = 1'b1;
          if (tail_phase) begin
            tail_sent = tail_sent + 8'd1;
            if (tail_sent == 8'd0 || tail_sent >= tail_r) begin
              s.frame_done = 1'b1;
              end_frame();
            end
          end else begin
            // store and scaling are read live for every slot
            word = grb_store[cur_led];
            word = {scaled_channel(word[23:16]), scaled_channel(word[15:8]),
                    scaled_channel(word[7:0])};
            s.duty = word[cur_bit] ? one_r : zero_r;
            if (cur_bit == 5'd0) begin
              cur_bit = BIT_POS_FIRST;
              if (cur_led + 1 >= LED_COUNT) begin
                if (tail_r == 8'd0) begin
                  s.frame_done = 1'b1;
                  end_frame();
                end else begin
                  tail_phase = 1'b1;
                  tail_sent  = '0;
                end
              end else begin
                cur_led++;
              end
            end else begin
              cur_bit--;
            end
          end
        end
        pending_slots.push_back(s);
      end
    endcase
  endfunction

  function automatic void apply_reg(input reg_idx_t ri, input logic [31:0] val);
    case (ri)
      REG_BRIGHTNESS: bright_r = (val[6:0] > BRIGHT_MAX) ? BRIGHT_MAX : val[6:0];
      REG_SCALE_EN:   scale_r  = val[0];
      REG_ONE_PULSE:  one_r    = val[7:0];
      REG_ZERO_PULSE: zero_r   = val[7:0];
      REG_TAIL_SLOTS: tail_r   = val[7:0];
      default: ;
    endcase
  endfunction

  task automatic send_request(input req_t rq, input logic [5:0] idx,
                              input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    start        <= 1'b1;
    in_req_type  <= rq;
    in_led_index <= idx;
    in_red       <= r;
    in_green     <= g;
    in_blue      <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_slot(rq, idx, r, g, b);
  endtask

  task automatic send_random(input req_t rq);
    send_request(rq, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // random colour for an LED at or just ahead of the one being sent
  task automatic write_near(input int unsigned ahead);
    send_request(REQ_WRITE, 6'(cur_led + ahead), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // start stays high after a beat, so it is dropped here and before a random gap in send_request
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves psel high so back-to-back writes need no extra step; release_cfg ends a burst
  task automatic write_reg(input reg_idx_t ri, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ri, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_reg(ri, val);
  endtask

  task automatic release_cfg();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_regs(input logic [31:0] bright, input logic [31:0] scale,
                              input logic [31:0] one, input logic [31:0] zero,
                              input logic [31:0] tail);
    wait_idle();
    write_reg(REG_BRIGHTNESS, bright);
    write_reg(REG_SCALE_EN, scale);
    write_reg(REG_ONE_PULSE, one);
    write_reg(REG_ZERO_PULSE, zero);
    write_reg(REG_TAIL_SLOTS, tail);
    release_cfg();
  endtask

  // a start that may be ignored, colours for the next LEDs, then slot ticks
  task automatic run_slots(input int ticks);
    send_random(REQ_START);
    for (int unsigned i = 0; i < 8; i++) write_near(i);
    repeat (ticks) send_random(REQ_TICK);
  endtask

  task automatic test_directed_requests();
    send_random(REQ_TICK);
    send_request(REQ_WRITE, 6'd0, 8'h00, 8'hFF, 8'hFF);
    send_request(REQ_WRITE, 6'd63, 8'hFF, 8'hFF, 8'hFF);
    send_request(REQ_WRITE, 6'd1, 8'h80, 8'h01, 8'h7F);
    send_random(REQ_TICK);
    send_random(REQ_CLEAR);
    send_request(REQ_WRITE, 6'd0, 8'h00, 8'h80, 8'h01);
    send_random(REQ_START);
    repeat (4) send_random(REQ_TICK);
    // second start while the frame runs must be ignored
    send_random(REQ_START);
    send_random(REQ_TICK);
    send_request(REQ_WRITE, 6'd0, 8'hFF, 8'hFF, 8'hFF);
    repeat (3) send_random(REQ_TICK);
    send_random(REQ_CLEAR);
    repeat (2) send_random(REQ_TICK);
    send_request(REQ_WRITE, 6'd62, 8'h55, 8'hAA, 8'h00);
  endtask

  task automatic test_register_settings();
    // raw colours, no latch slots
    program_regs(32'd127, 32'd0, 32'd255, 32'd0, 32'd0);
    run_slots(48);
    // junk above the field widths, brightness 101 saturates
    program_regs(32'hFFFF_FF65, 32'hFFFF_FFFF, 32'hFFFF_FF00, 32'h1234_56FF,
                 32'hABCD_EF01);
    run_slots(48);
    // zero brightness blanks every channel
    program_regs(32'd0, 32'd1, 32'd1, 32'd254, 32'd50);
    run_slots(48);
  endtask

  task automatic test_midframe_changes();
    program_regs(32'd100, 32'd1, 32'd40, 32'd20, 32'd50);
    write_near(0);
    write_near(1);
    repeat (24) send_random(REQ_TICK);
    // the LED being sent is rewritten and then cleared part way through its bits
    write_near(0);
    repeat (8) send_random(REQ_TICK);
    send_random(REQ_CLEAR);
    repeat (8) send_random(REQ_TICK);
    write_near(0);
    write_near(1);
    repeat (8) send_random(REQ_TICK);
    wait_idle();
    write_reg(REG_BRIGHTNESS, 32'd55);
    write_reg(REG_ONE_PULSE, 32'd200);
    release_cfg();
    repeat (16) send_random(REQ_TICK);
    wait_idle();
    write_reg(REG_SCALE_EN, 32'd0);
    release_cfg();
    write_near(0);
    write_near(1);
    repeat (24) send_random(REQ_TICK);
  endtask

  task automatic test_random_traffic(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      if (n == count - count / 4) gaps_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 70)      send_random(REQ_TICK);
      else if (pick < 88) write_near($urandom_range(0, 3));
      else if (pick < 92) send_random(REQ_WRITE);
      else if (pick < 95) send_random(REQ_CLEAR);
      else                send_random(REQ_START);
      if ($urandom_range(0, 59) == 0) begin
        wait_idle();
        write_reg(reg_idx_t'($urandom_range(0, 4)), $urandom);
        release_cfg();
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    slot_t want;
    if (rst_n && out_valid) begin
      if (pending_slots.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected beat: duty %0d active %0b frame_done %0b",
                   out_duty, out_active, out_frame_done);
        end
        mismatches++;
      end else begin
        want = pending_slots.pop_front();
        if (out_duty !== want.duty || out_active !== want.active ||
            out_frame_done !== want.frame_done) begin
          if (mismatches < 10) begin
            $display("slot mismatch: expected duty %0d active %0b frame_done %0b, got %0d %0b %0b",
                     want.duty, want.active, want.frame_done,
                     out_duty, out_active, out_frame_done);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pwrite && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    foreach (grb_store[i]) grb_store[i] = '0;
    end_frame();
    bright_r = BRIGHT_RST;
    scale_r  = SCALE_EN_RST;
    one_r    = ONE_PULSE_RST;
    zero_r   = ZERO_PULSE_RST;
    tail_r   = TAIL_SLOTS_RST;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_requests();
    test_register_settings();
    test_midframe_changes();
    test_random_traffic(300);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
